>>> sv/rcpu_pkg.sv
`timescale 1ns / 1ps

package rcpu_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LOSS_LIMIT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_MAX   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STICK_DEADBAND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STICK_CENTER   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_FLOOR = 3'd4;

  // configuration reset values
  localparam logic [7:0] LOSS_LIMIT_RST     = 8'd200;
  localparam logic [9:0] THROTTLE_MAX_RST   = 10'd950;
  localparam logic [6:0] STICK_DEADBAND_RST = 7'd5;
  localparam logic [6:0] STICK_CENTER_RST   = 7'd50;
  localparam logic [9:0] THROTTLE_FLOOR_RST = 10'd10;

  localparam logic [7:0] TRAILER_MARK = 8'h8B;
  localparam logic [9:0] THROTTLE_CAP = 10'd1000;

  typedef logic signed [8:0] stick_t;

endpackage

>>> sv/rc_packet_unpack_failsafe.sv
`timescale 1ns / 1ps

// Radio-control packet unpacker with link-loss failsafe.
// Input channel: one transaction per polling tick (rx_ok plus packet bytes),
// handshake in_valid / in_stall. Output channel: one status transaction per
// input transaction, handshake out_valid / out_stall.
// The status for a tick is valid on the cycle after the input transaction.
// Unless stalled, throughput is one tick per cycle; all decoding, clamping,
// deadband and miss counting is a single combinational pass into the state
// registers, which drive the output fields directly.
// The output holding stage is the state registers plus out_valid. While a
// status waits and out_stall is high, in_stall is raised and nothing changes;
// when the waiting status is taken in the same cycle a new tick is accepted.
// Reset (rst, synchronous) clears all state to zero, link flagged normal, no
// status pending, and loads the configuration registers with their defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply at the next edge;
// the user makes them while the block is idle (not enforced). Good packets
// (trailer 0x8B) update throttle, sticks and keys; bad trailers change nothing;
// missed ticks count to loss_limit, then throttle ramps down to throttle_floor.
module rc_packet_unpack_failsafe
  import rcpu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   rx_ok,
  input  logic [7:0]             throttle_low_byte,
  input  logic [7:0]             throttle_high_byte,
  input  logic [7:0]             pitch_byte,
  input  logic [7:0]             roll_byte,
  input  logic [7:0]             yaw_byte,
  input  logic [7:0]             left_key_byte,
  input  logic [7:0]             right_key_byte,
  input  logic [7:0]             trailer_byte,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [9:0]             throttle_out,
  output logic [9:0]             hold_throttle,
  output logic signed [8:0]      pitch_out,
  output logic signed [8:0]      roll_out,
  output logic signed [8:0]      yaw_out,
  output logic [7:0]             left_key,
  output logic [7:0]             right_key,
  output logic                   link_lost
);

  logic [7:0] loss_limit;
  logic [9:0] throttle_max;
  logic [6:0] stick_deadband;
  logic [6:0] stick_center;
  logic [9:0] throttle_floor;

  logic [9:0] throttle_reg, throttle_next;
  logic [9:0] hold_throttle_reg, hold_throttle_next;
  stick_t     pitch_reg, pitch_next;
  stick_t     roll_reg, roll_next;
  stick_t     yaw_reg, yaw_next;
  logic [7:0] left_key_reg, left_key_next;
  logic [7:0] right_key_reg, right_key_next;
  logic [7:0] miss_count, miss_count_next;
  logic       lost_flag, lost_flag_next;

  logic        in_accept;
  logic        good_packet;
  logic [15:0] raw_throttle;
  logic [9:0]  throttle_cap;
  logic [9:0]  ramp_throttle;
  logic        below_limit;
  logic        at_limit;

  function automatic stick_t stick_value(input logic [7:0] b, input logic negate,
                                         input logic [6:0] center,
                                         input logic [6:0] deadband);
    logic signed [9:0] v;
    logic [9:0]        mag;
    v = $signed({{2{b[7]}}, b}) - $signed({3'b000, center});
    if (negate) v = -v;
    mag = v[9] ? 10'(-v) : 10'(v);
    if (mag <= {3'b000, deadband}) v = '0;
    return v[8:0];
  endfunction

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_limit     <= LOSS_LIMIT_RST;
      throttle_max   <= THROTTLE_MAX_RST;
      stick_deadband <= STICK_DEADBAND_RST;
      stick_center   <= STICK_CENTER_RST;
      throttle_floor <= THROTTLE_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOSS_LIMIT:     loss_limit     <= cfg_data[7:0];
        REG_THROTTLE_MAX:   throttle_max   <= cfg_data;
        REG_STICK_DEADBAND: stick_deadband <= cfg_data[6:0];
        REG_STICK_CENTER:   stick_center   <= cfg_data[6:0];
        REG_THROTTLE_FLOOR: throttle_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign good_packet  = rx_ok && (trailer_byte == TRAILER_MARK);
  assign raw_throttle = {throttle_high_byte, throttle_low_byte};
  assign throttle_cap = (throttle_max > THROTTLE_CAP) ? THROTTLE_CAP : throttle_max;
  assign below_limit  = miss_count < loss_limit;
  // limit check uses the counter after this tick's increment
  assign at_limit     = (below_limit ? 9'(miss_count) + 9'd1 : 9'(miss_count))
                        >= 9'(loss_limit);
  assign ramp_throttle = (at_limit && throttle_reg > throttle_floor)
                         ? throttle_reg - 10'd1 : throttle_reg;

  always_comb begin
    throttle_next      = throttle_reg;
    hold_throttle_next = hold_throttle_reg;
    pitch_next         = pitch_reg;
    roll_next          = roll_reg;
    yaw_next           = yaw_reg;
    left_key_next      = left_key_reg;
    right_key_next     = right_key_reg;
    miss_count_next    = miss_count;
    lost_flag_next     = lost_flag;
    if (rx_ok) begin
      if (good_packet) begin
        throttle_next      = (raw_throttle > 16'(throttle_cap)) ? throttle_cap
                                                                : raw_throttle[9:0];
        hold_throttle_next = throttle_next;
        pitch_next         = stick_value(pitch_byte, 1'b1, stick_center, stick_deadband);
        roll_next          = stick_value(roll_byte, 1'b1, stick_center, stick_deadband);
        yaw_next           = stick_value(yaw_byte, 1'b0, stick_center, stick_deadband);
        left_key_next      = left_key_byte;
        right_key_next     = right_key_byte;
        miss_count_next    = '0;
      end
    end else begin
      if (below_limit) begin
        miss_count_next = miss_count + 8'd1;
        lost_flag_next  = 1'b0;
      end
      if (at_limit) lost_flag_next = 1'b1;
      throttle_next = (ramp_throttle > THROTTLE_CAP) ? THROTTLE_CAP : ramp_throttle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_reg      <= '0;
      hold_throttle_reg <= '0;
      pitch_reg         <= '0;
      roll_reg          <= '0;
      yaw_reg           <= '0;
      left_key_reg      <= '0;
      right_key_reg     <= '0;
      miss_count        <= '0;
      lost_flag         <= 1'b0;
    end else if (in_accept) begin
      throttle_reg      <= throttle_next;
      hold_throttle_reg <= hold_throttle_next;
      pitch_reg         <= pitch_next;
      roll_reg          <= roll_next;
      yaw_reg           <= yaw_next;
      left_key_reg      <= left_key_next;
      right_key_reg     <= right_key_next;
      miss_count        <= miss_count_next;
      lost_flag         <= lost_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // state registers are the status payload
  assign throttle_out  = throttle_reg;
  assign hold_throttle = hold_throttle_reg;
  assign pitch_out     = pitch_reg;
  assign roll_out      = roll_reg;
  assign yaw_out       = yaw_reg;
  assign left_key      = left_key_reg;
  assign right_key     = right_key_reg;
  assign link_lost     = lost_flag;

  a_lost_on_miss: assert property (@(posedge clk) disable iff (rst)
    $rose(lost_flag) |-> $past(in_accept && !rx_ok))
    else $error("link flagged lost without a missed tick");

  a_good_clears_miss: assert property (@(posedge clk) disable iff (rst)
    in_accept && good_packet |=> miss_count == 8'd0)
    else $error("good packet did not clear the miss counter");

  a_bad_trailer_no_change: assert property (@(posedge clk) disable iff (rst)
    in_accept && rx_ok && !good_packet |=>
      $stable(throttle_reg) && $stable(miss_count) && $stable(hold_throttle_reg))
    else $error("bad trailer changed state");

  a_throttle_capped: assert property (@(posedge clk) disable iff (rst)
    throttle_reg <= THROTTLE_CAP && hold_throttle_reg <= THROTTLE_CAP)
    else $error("throttle above cap");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcpu_pkg::*;

  typedef struct {
    logic       rx_ok;
    logic [7:0] thr_lo;
    logic [7:0] thr_hi;
    logic [7:0] pitch;
    logic [7:0] roll;
    logic [7:0] yaw;
    logic [7:0] lkey;
    logic [7:0] rkey;
    logic [7:0] trailer;
  } tick_t;

  typedef struct {
    logic [9:0] throttle;
    logic [9:0] hold;
    stick_t     pitch;
    stick_t     roll;
    stick_t     yaw;
    logic [7:0] lkey;
    logic [7:0] rkey;
    logic       lost;
  } status_t;

  // Scoreboard: mirrors the receiver state and keeps the status queue.
  class status_scoreboard;
    logic [7:0] loss_limit;
    logic [9:0] throttle_max;
    logic [6:0] deadband;
    logic [6:0] center;
    logic [9:0] floor_lvl;
    status_t    cur;
    logic [7:0] misses;
    status_t    pending_q[$];
    int         errors;

    function void clear();
      loss_limit   = LOSS_LIMIT_RST;
      throttle_max = THROTTLE_MAX_RST;
      deadband     = STICK_DEADBAND_RST;
      center       = STICK_CENTER_RST;
      floor_lvl    = THROTTLE_FLOOR_RST;
      cur          = '{default: '0};
      misses       = '0;
      errors       = 0;
      pending_q.delete();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LOSS_LIMIT:     loss_limit = val[7:0];
        REG_THROTTLE_MAX:   throttle_max = val;
        REG_STICK_DEADBAND: deadband = val[6:0];
        REG_STICK_CENTER:   center = val[6:0];
        REG_THROTTLE_FLOOR: floor_lvl = val;
        default: ;
      endcase
    endfunction

    function stick_t stick_cmd(logic [7:0] b, bit negate);
      int v;
      v = int'($signed(b)) - int'(center);
      if (negate) v = -v;
      if ((v < 0 ? -v : v) <= int'(deadband)) v = 0;
      return stick_t'(v);
    endfunction

    function logic [9:0] throttle_cap();
      return (throttle_max > THROTTLE_CAP) ? THROTTLE_CAP : throttle_max;
    endfunction

    function void note_tick(tick_t t);
      logic [15:0] raw;
      logic [9:0]  cap;
      if (t.rx_ok) begin
        if (t.trailer == TRAILER_MARK) begin
          raw = {t.thr_hi, t.thr_lo};
          cap = throttle_cap();
          misses = '0;
          cur.throttle = (raw > cap) ? cap : raw[9:0];
          cur.pitch = stick_cmd(t.pitch, 1'b1);
          cur.roll = stick_cmd(t.roll, 1'b1);
          cur.yaw = stick_cmd(t.yaw, 1'b0);
          cur.lkey = t.lkey;
          cur.rkey = t.rkey;
          cur.hold = cur.throttle;
        end
      end else begin
        // counter holds once at or past the limit, even if the limit was lowered
        if (misses < loss_limit) begin
          misses++;
          cur.lost = 1'b0;
        end
        if (misses >= loss_limit) begin
          cur.lost = 1'b1;
          if (cur.throttle > floor_lvl) cur.throttle--;
        end
        if (cur.throttle > THROTTLE_CAP) cur.throttle = THROTTLE_CAP;
      end
      pending_q.push_back(cur);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: status transaction with no tick pending", $time);
        return;
      end
      want = pending_q.pop_front();
      compare_field("throttle_out", want.throttle, got.throttle);
      compare_field("hold_throttle", want.hold, got.hold);
      compare_field("pitch_out", want.pitch, got.pitch);
      compare_field("roll_out", want.roll, got.roll);
      compare_field("yaw_out", want.yaw, got.yaw);
      compare_field("left_key", want.lkey, got.lkey);
      compare_field("right_key", want.rkey, got.rkey);
      compare_field("link_lost", want.lost, got.lost);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   rx_ok = 1'b0;
  logic [7:0]             throttle_low_byte = '0;
  logic [7:0]             throttle_high_byte = '0;
  logic [7:0]             pitch_byte = '0;
  logic [7:0]             roll_byte = '0;
  logic [7:0]             yaw_byte = '0;
  logic [7:0]             left_key_byte = '0;
  logic [7:0]             right_key_byte = '0;
  logic [7:0]             trailer_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [9:0]             throttle_out;
  logic [9:0]             hold_throttle;
  logic signed [8:0]      pitch_out;
  logic signed [8:0]      roll_out;
  logic signed [8:0]      yaw_out;
  logic [7:0]             left_key;
  logic [7:0]             right_key;
  logic                   link_lost;

  bit gap_mode = 1'b1;
  bit stall_mode = 1'b1;
  status_scoreboard sb;

  rc_packet_unpack_failsafe u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_ok              (rx_ok),
    .throttle_low_byte  (throttle_low_byte),
    .throttle_high_byte (throttle_high_byte),
    .pitch_byte         (pitch_byte),
    .roll_byte          (roll_byte),
    .yaw_byte           (yaw_byte),
    .left_key_byte      (left_key_byte),
    .right_key_byte     (right_key_byte),
    .trailer_byte       (trailer_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .throttle_out       (throttle_out),
    .hold_throttle      (hold_throttle),
    .pitch_out          (pitch_out),
    .roll_out           (roll_out),
    .yaw_out            (yaw_out),
    .left_key           (left_key),
    .right_key          (right_key),
    .link_lost          (link_lost)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_status('{throttle_out, hold_throttle, pitch_out, roll_out, yaw_out,
                        left_key, right_key, link_lost});
    end
  end

  // status receiver back-pressure
  initial begin
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = stall_mode ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(input tick_t t);
    int gap;
    gap = gap_mode ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    rx_ok              <= t.rx_ok;
    throttle_low_byte  <= t.thr_lo;
    throttle_high_byte <= t.thr_hi;
    pitch_byte         <= t.pitch;
    roll_byte          <= t.roll;
    yaw_byte           <= t.yaw;
    left_key_byte      <= t.lkey;
    right_key_byte     <= t.rkey;
    trailer_byte       <= t.trailer;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  // drop valid and let the block drain before touching configuration
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tick_t good_pkt(logic [15:0] thr, logic [7:0] p, logic [7:0] r,
                                     logic [7:0] y, logic [7:0] lk, logic [7:0] rk);
    return '{1'b1, thr[7:0], thr[15:8], p, r, y, lk, rk, TRAILER_MARK};
  endfunction

  function automatic tick_t miss_tick();
    tick_t t;
    t = '{1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    if ($urandom_range(0, 1)) t.trailer = TRAILER_MARK;
    return t;
  endfunction

  function automatic tick_t bad_pkt(logic [7:0] trailer);
    tick_t t;
    t = miss_tick();
    t.rx_ok = 1'b1;
    t.trailer = trailer;
    return t;
  endfunction

  function automatic logic [7:0] rand_trailer_bad();
    logic [7:0] b;
    do b = 8'($urandom); while (b == TRAILER_MARK);
    return b;
  endfunction

  // stick bytes cluster around the deadband edges two thirds of the time
  function automatic logic [7:0] rand_stick();
    case ($urandom_range(0, 2))
      0: return 8'($urandom);
      1: return 8'(int'(sb.center) + int'(sb.deadband) + $urandom_range(0, 1));
      default: return 8'(int'(sb.center) - int'(sb.deadband) - $urandom_range(0, 1));
    endcase
  endfunction

  function automatic tick_t rand_good();
    int thr;
    case ($urandom_range(0, 3))
      0: thr = $urandom_range(0, 65535);
      1: thr = $urandom_range(0, 1023);
      2: thr = int'(sb.throttle_cap()) + $urandom_range(0, 4) - 2;
      default: thr = int'(sb.floor_lvl) + $urandom_range(0, 3);
    endcase
    return good_pkt(16'(thr), rand_stick(), rand_stick(), rand_stick(),
                    8'($urandom), 8'($urandom));
  endfunction

  // runs of good packets, runs of missed ticks up to max_run long that can trip the limit, some noise
  task automatic run_random(input int count, input int max_run);
    int sent;
    int run;
    int kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        run = $urandom_range(1, 8);
        repeat (run) send(rand_good());
      end else if (kind < 85) begin
        run = $urandom_range(1, max_run);
        repeat (run) send(miss_tick());
      end else begin
        run = 1;
        send(bad_pkt(rand_trailer_bad()));
      end
      sent += run;
    end
  endtask

  initial begin
    int waited;
    int lim;
    sb = new;
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: center 50, deadband 5, max 950, limit 200, floor 10
    send(good_pkt(16'h0000, 8'h00, 8'h7F, 8'h80, 8'h00, 8'hFF));
    send(good_pkt(16'hFFFF, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'h00));
    send(good_pkt(16'd950, 8'd55, 8'd56, 8'd45, 8'hA5, 8'h5A));
    send(good_pkt(16'd951, 8'd44, 8'd45, 8'd56, 8'h5A, 8'hA5));
    send(good_pkt(16'h03FF, 8'd50, 8'h01, 8'hFE, 8'h01, 8'h80));
    send(bad_pkt(8'h8A));
    send(bad_pkt(8'h0B));
    send(bad_pkt(8'hFF));
    send(miss_tick());

    // trip the limit, ramp down to the floor, recover
    settle();
    program_reg(REG_LOSS_LIMIT, 10'd3);
    program_reg(REG_THROTTLE_FLOOR, 10'd5);
    send(good_pkt(16'd7, 8'h10, 8'hF0, 8'h40, 8'h11, 8'h22));
    repeat (6) send(miss_tick());
    send(good_pkt(16'd300, 8'h60, 8'h20, 8'hC0, 8'h33, 8'h44));
    repeat (3) send(miss_tick());

    // limit lowered below the current count
    settle();
    program_reg(REG_LOSS_LIMIT, 10'd1);
    send(miss_tick());

    // zero limit, throttle_max above the cap
    settle();
    program_reg(REG_LOSS_LIMIT, 10'd0);
    program_reg(REG_THROTTLE_MAX, 10'd1023);
    send(good_pkt(16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(miss_tick());
    send(miss_tick());
    send(good_pkt(16'd1010, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    for (int p = 0; p < 7; p++) begin
      settle();
      gap_mode = (p % 2 == 1);
      stall_mode = (p % 3 != 0);
      case (p)
        0: begin
          lim = 1;
          program_reg(REG_LOSS_LIMIT, 10'd1);
          program_reg(REG_THROTTLE_MAX, 10'd0);
          program_reg(REG_STICK_DEADBAND, 10'd0);
          program_reg(REG_STICK_CENTER, 10'd0);
          program_reg(REG_THROTTLE_FLOOR, 10'd1000);
        end
        1: begin
          lim = 255;
          program_reg(REG_LOSS_LIMIT, 10'd255);
          program_reg(REG_THROTTLE_MAX, 10'd1023);
          program_reg(REG_STICK_DEADBAND, 10'd127);
          program_reg(REG_STICK_CENTER, 10'd127);
          program_reg(REG_THROTTLE_FLOOR, 10'd0);
        end
        default: begin
          lim = $urandom_range(1, 24);
          program_reg(REG_LOSS_LIMIT, 10'(lim));
          program_reg(REG_THROTTLE_MAX, 10'($urandom_range(0, 1023)));
          program_reg(REG_STICK_DEADBAND, 10'($urandom_range(0, 127)));
          program_reg(REG_STICK_CENTER, 10'($urandom_range(0, 127)));
          program_reg(REG_THROTTLE_FLOOR, 10'($urandom_range(0, 200)));
        end
      endcase
      run_random(p == 1 ? 300 : (p == 0 ? 110 : 85), lim + 15);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected status transactions never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
